// ===== hw/rtl/ffha_pkg.sv =====
package ffha_pkg;

	localparam int unsigned POOL_BYTES_DEF = 65536;
	localparam int unsigned PAGE_BYTES_DEF = 4096;
	localparam int unsigned UNIT_BYTES_DEF = 16;

	localparam int unsigned REQ_W  = 16;
	localparam int unsigned ADDR_W = 16;
	localparam int unsigned FLAG_W = 3;

	localparam logic [FLAG_W-1:0] FL_FREE = 3'd1;
	localparam logic [FLAG_W-1:0] FL_LAST = 3'd2;
	localparam logic [FLAG_W-1:0] FL_LINK = 3'd4;
	localparam logic [FLAG_W-1:0] FL_NONE = 3'd0;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NONE,
		OP_START,
		OP_READ_B,
		OP_READ_NEXT,
		OP_GROW_CHECK,
		OP_GROW_HDR,
		OP_GROW_TAIL,
		OP_LINK_WR,
		OP_FOLLOW_LINK,
		OP_MERGE_WR,
		OP_BUMP,
		OP_STEP_NEXT,
		OP_SPLIT_HDR,
		OP_SPLIT_TAIL,
		OP_FREE_WR,
		OP_VISIT,
		OP_LATCH_H,
		OP_LATCH_NH
	} op_t;

	typedef struct packed {
		op_t  op;
		logic grow_first;
	} ctl_cmd_t;

	typedef struct packed {
		logic h_free;
		logic h_last;
		logic h_link;
		logic nh_free;
		logic nh_last;
		logic bsize_lt;
		logic bsize_gt;
		logic grow_fail;
		logic fresh;
		logic first_valid;
		logic over;
		logic free_zero;
		logic is_free;
	} ctl_sts_t;

endpackage

// ===== hw/rtl/ffha_ram.sv =====
module ffha_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/ffha_datapath.sv =====
module ffha_datapath import ffha_pkg::*; #(
	parameter int unsigned POOL_BYTES = POOL_BYTES_DEF,
	parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF,
	parameter int unsigned UNIT_BYTES = UNIT_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              command,
	input  logic [REQ_W-1:0]  req_bytes,
	input  logic [ADDR_W-1:0] block_addr,
	input  ctl_cmd_t          cmd,
	output ctl_sts_t          sts,
	output logic [ADDR_W-1:0] user_addr
);
	localparam int unsigned UNITS  = POOL_BYTES / UNIT_BYTES;
	localparam int unsigned UIDX_W = $clog2(UNITS);
	localparam int unsigned VAL_W  = UIDX_W + 1;
	localparam int unsigned HDR_W  = VAL_W + FLAG_W;
	localparam int unsigned UB_SH  = $clog2(UNIT_BYTES);
	localparam int unsigned PG_SH  = $clog2(PAGE_BYTES / UNIT_BYTES);
	localparam int unsigned WL_W   = UIDX_W + 4;
	localparam int unsigned ALN_W  = REQ_W + 8;
	localparam logic [WL_W-1:0] WALK_LIMIT = WL_W'(4 * UNITS + 16);

	logic [UIDX_W-1:0] b_q;
	logic [ALN_W-1:0]  req_q;
	logic [VAL_W-1:0]  t_q;
	logic [HDR_W-1:0]  h_q, nh_q;
	logic [WL_W-1:0]   visits_q;
	logic [UIDX_W:0]   gp_q;
	logic              exh_q, fresh_q, fv_q, cmd_q;
	logic [UIDX_W-1:0] fc_q;
	logic [ADDR_W-1:0] faddr_q;

	logic              we;
	logic [UIDX_W-1:0] waddr, raddr;
	logic [HDR_W-1:0]  wdata, rdata;

	ffha_ram #(.WIDTH(HDR_W), .DEPTH(UNITS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [ALN_W-1:0] align;
	logic [ALN_W-1:0] n_units;
	logic [UIDX_W:0]  gp_new;
	logic [VAL_W-1:0] hval, nhval;
	logic [UIDX_W-1:0] next_b;

	assign align = (req_q + ALN_W'(UNIT_BYTES - 1)) >> UB_SH;
	// chunk: round up to pages, or one page more when already aligned
	assign n_units = ((align >> PG_SH) + ALN_W'(1)) << PG_SH;
	// base of the chunk being grown
	assign gp_new = gp_q - n_units[UIDX_W:0];
	assign hval  = h_q[HDR_W-1:FLAG_W];
	assign nhval = nh_q[HDR_W-1:FLAG_W];
	// next header follows the current (possibly merged) size
	assign next_b = b_q + t_q[UIDX_W-1:0] + UIDX_W'(1);

	logic [VAL_W-1:0] bsize;
	assign bsize = t_q;

	always_comb begin
		we = 1'b0;
		waddr = b_q;
		wdata = '0;
		raddr = b_q;
		unique case (cmd.op)
			OP_READ_NEXT:  raddr = next_b;
			OP_GROW_HDR: begin
				we = 1'b1;
				waddr = UIDX_W'(gp_q - n_units[UIDX_W:0]);
				wdata = {VAL_W'(n_units - ALN_W'(2)), FL_FREE};
			end
			OP_GROW_TAIL: begin
				we = 1'b1;
				waddr = UIDX_W'(gp_q - UIDX_W'(1));
				wdata = {VAL_W'(0), FL_LAST};
			end
			OP_LINK_WR: begin
				we = 1'b1;
				wdata = {VAL_W'(gp_new), FL_LAST | FL_LINK};
			end
			OP_MERGE_WR: begin
				we = 1'b1;
				wdata = {VAL_W'(t_q + nhval + VAL_W'(1)), FL_FREE};
			end
			OP_SPLIT_HDR: begin
				we = 1'b1;
				wdata = {VAL_W'(align), FL_NONE};
			end
			OP_SPLIT_TAIL: begin
				we = 1'b1;
				waddr = b_q + UIDX_W'(align) + UIDX_W'(1);
				wdata = {VAL_W'(bsize - VAL_W'(align) - VAL_W'(1)), FL_FREE};
			end
			OP_FREE_WR: begin
				we = 1'b1;
				wdata = {hval, FL_FREE};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q <= (UIDX_W+1)'(UNITS);
			exh_q <= 1'b0;
			fv_q <= 1'b0;
			fc_q <= '0;
			visits_q <= '0;
			fresh_q <= 1'b0;
		end else begin
			if (load) begin
				visits_q <= '0;
				fresh_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_VISIT: visits_q <= visits_q + WL_W'(1);
				OP_GROW_CHECK: if (sts.grow_fail) exh_q <= 1'b1;
				OP_GROW_TAIL: begin
					gp_q <= gp_q - n_units[UIDX_W:0];
					fresh_q <= 1'b1;
					if (cmd.grow_first) begin
						fv_q <= 1'b1;
						fc_q <= UIDX_W'(gp_q - n_units[UIDX_W:0]);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= command;
			req_q <= ALN_W'(req_bytes);
			faddr_q <= block_addr;
			b_q <= UIDX_W'((block_addr >> UB_SH) - ADDR_W'(1));
		end
		unique case (cmd.op)
			OP_START:       b_q <= fc_q;
			OP_LATCH_H: begin
				h_q <= rdata;
				t_q <= rdata[HDR_W-1:FLAG_W];
			end
			OP_LATCH_NH:    nh_q <= rdata;
			OP_MERGE_WR:    t_q <= t_q + nhval + VAL_W'(1);
			OP_STEP_NEXT:   b_q <= next_b;
			OP_BUMP: begin
				req_q <= req_q + ALN_W'(2 * UNIT_BYTES);
				b_q <= next_b;
			end
			OP_FOLLOW_LINK: b_q <= hval[UIDX_W-1:0];
			OP_LINK_WR:     b_q <= UIDX_W'(gp_new);
			OP_SPLIT_HDR:   user_addr <= ADDR_W'((ALN_W'(b_q) + ALN_W'(1)) << UB_SH);
			default: ;
		endcase
	end

	assign sts.h_free  = h_q[0];
	assign sts.h_last  = h_q[1];
	assign sts.h_link  = h_q[2];
	assign sts.nh_free = nh_q[0];
	assign sts.nh_last = nh_q[1];
	assign sts.bsize_lt = {1'b0, bsize} < (VAL_W+1)'(align) || |align[ALN_W-1:VAL_W];
	assign sts.bsize_gt = !sts.bsize_lt && ALN_W'(bsize) != align;
	assign sts.grow_fail = exh_q || n_units > ALN_W'(gp_q);
	assign sts.fresh = fresh_q;
	assign sts.first_valid = fv_q;
	assign sts.over = visits_q >= WALK_LIMIT;
	assign sts.free_zero = faddr_q == '0;
	assign sts.is_free = cmd_q;
endmodule

// ===== hw/rtl/ffha_ctrl.sv =====
module ffha_ctrl import ffha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     load,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd,
	output logic     done,
	output logic     ok
);
	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_GROW   = 16'h0002,
		S_GHDR   = 16'h0004,
		S_GTAIL  = 16'h0008,
		S_VISIT  = 16'h0010,
		S_RDH    = 16'h0020,
		S_LATH   = 16'h0040,
		S_DECIDE = 16'h0080,
		S_MVISIT = 16'h0100,
		S_RDN    = 16'h0200,
		S_LATN   = 16'h0400,
		S_MCHK   = 16'h0800,
		S_POST   = 16'h1000,
		S_SPLIT  = 16'h2000,
		S_FREEW  = 16'h4000,
		S_DONE   = 16'h8000
	} st_t;

	st_t st_q, nxt;
	logic ok_q, ok_d, gf_q, gf_d;

	assign busy = st_q != S_IDLE;
	assign load = start && !busy;

	always_comb begin
		nxt = st_q;
		cmd = '{op: OP_NONE, grow_first: gf_q};
		ok_d = ok_q;
		gf_d = gf_q;
		unique case (st_q)
			S_IDLE: if (load) begin
				nxt = S_RDH;
				ok_d = 1'b1;
				gf_d = 1'b0;
			end
			S_RDH: begin
				cmd.op = OP_READ_B;
				if (sts.is_free) begin
					if (sts.free_zero) nxt = S_DONE;
					else nxt = S_LATH;
				end else if (!sts.first_valid) begin
					gf_d = 1'b1;
					nxt = S_GROW;
				end else begin
					cmd.op = OP_START;
					nxt = S_VISIT;
				end
			end
			S_GROW: begin
				cmd.op = OP_GROW_CHECK;
				if (sts.grow_fail) begin
					ok_d = 1'b0;
					nxt = S_DONE;
				end else if (gf_q) nxt = S_GHDR;
				else begin
					cmd.op = OP_LINK_WR;
					nxt = S_GHDR;
				end
			end
			S_GHDR: begin cmd.op = OP_GROW_HDR; nxt = S_GTAIL; end
			S_GTAIL: begin
				cmd.op = OP_GROW_TAIL;
				if (gf_q) begin
					gf_d = 1'b0;
					nxt = S_RDH;
				end else nxt = S_VISIT;
			end
			S_VISIT: begin
				if (sts.over) begin
					ok_d = 1'b0;
					nxt = S_DONE;
				end else begin
					cmd.op = OP_VISIT;
					nxt = S_LATH;
				end
			end
			S_LATH: begin
				cmd.op = OP_LATCH_H;
				nxt = sts.is_free ? S_FREEW : S_DECIDE;
			end
			S_FREEW: begin
				cmd.op = OP_FREE_WR;
				nxt = S_MVISIT;
			end
			S_DECIDE: begin
				if (sts.h_free) begin
					if (sts.bsize_lt && !sts.h_last) begin
						nxt = S_MVISIT;
					end else nxt = S_POST;
				end else if (sts.h_last) begin
					if (sts.h_link) begin
						cmd.op = OP_FOLLOW_LINK;
						nxt = S_VISIT;
					end else nxt = S_GROW;
				end else begin
					cmd.op = OP_STEP_NEXT;
					nxt = S_VISIT;
				end
			end
			S_MVISIT: begin
				if (sts.over) nxt = sts.is_free ? S_DONE : S_POST;
				else begin
					cmd.op = OP_VISIT;
					nxt = S_RDN;
				end
			end
			S_RDN:  begin cmd.op = OP_READ_NEXT; nxt = S_LATN; end
			S_LATN: begin cmd.op = OP_LATCH_NH; nxt = S_MCHK; end
			S_MCHK: begin
				if (sts.nh_last || !sts.nh_free)
					nxt = sts.is_free ? S_DONE : S_POST;
				else begin
					cmd.op = OP_MERGE_WR;
					nxt = S_MVISIT;
				end
			end
			S_POST: begin
				if (sts.fresh && sts.bsize_lt) begin
					cmd.op = OP_BUMP;
					nxt = S_VISIT;
				end else if (!sts.bsize_lt) begin
					cmd.op = OP_SPLIT_HDR;
					nxt = S_SPLIT;
				end else begin
					cmd.op = OP_STEP_NEXT;
					nxt = S_VISIT;
				end
			end
			S_SPLIT: begin
				cmd.op = sts.bsize_gt ? OP_SPLIT_TAIL : OP_NONE;
				nxt = S_DONE;
			end
			S_DONE: nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end

	// user_addr is captured with the split header write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ok_q <= 1'b0;
			gf_q <= 1'b0;
		end else begin
			st_q <= nxt;
			ok_q <= ok_d;
			gf_q <= gf_d;
		end
	end

	assign done = st_q == S_DONE;
	assign ok = ok_q;
endmodule

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// channel   signals                             handshake
// request   command, req_bytes, block_addr       start high while busy low
// result    ok, user_addr                        done high for one cycle
//
// every header visited takes a read, a latch and a decide step, every
// neighbor merged a visit, read, latch and check step, every grow a
// check, header write and tail write step, so the time follows heap
// fragmentation (the ram's single read port sets it)
// reset sets the grow pointer to the pool top and clears chunk state; the header ram needs no clear
// results cannot be stalled: done pulses exactly once per accepted item
module first_fit_heap_allocator import ffha_pkg::*; #(
	parameter int unsigned POOL_BYTES = POOL_BYTES_DEF,
	parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF,
	parameter int unsigned UNIT_BYTES = UNIT_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              command,
	input  logic [REQ_W-1:0]  req_bytes,
	input  logic [ADDR_W-1:0] block_addr,
	output logic              done,
	output logic              ok,
	output logic [ADDR_W-1:0] user_addr
);
	ctl_cmd_t cmd;
	ctl_sts_t sts;
	logic load, ok_i;
	logic [ADDR_W-1:0] addr_i;

	// controller: walk sequencing
	ffha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .load(load),
		.sts(sts), .cmd(cmd), .done(done), .ok(ok_i)
	);

	// datapath: header ram, walk pointer, grow pointer
	ffha_datapath #(
		.POOL_BYTES(POOL_BYTES), .PAGE_BYTES(PAGE_BYTES), .UNIT_BYTES(UNIT_BYTES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .load(load), .command(command),
		.req_bytes(req_bytes), .block_addr(block_addr), .cmd(cmd), .sts(sts),
		.user_addr(addr_i)
	);

	// free commands and failures report a zero address
	assign ok = ok_i;
	assign user_addr = (ok_i && !sts.is_free) ? addr_i : '0;
endmodule

// ===== hw/rtl/ffha_checker.sv =====
module ffha_props import ffha_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic              ok,
	input logic [ADDR_W-1:0] user_addr
);
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accept without busy");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> user_addr == '0) else $error("address on failure");
endmodule

bind first_fit_heap_allocator ffha_props u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .ok(ok), .user_addr(user_addr)
);

// ===== dv/ffha_checker.sv =====
module ffha_checker import ffha_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              command,
	input  logic [REQ_W-1:0]  req_bytes,
	input  logic [ADDR_W-1:0] block_addr,
	input  logic              done,
	input  logic              ok,
	input  logic [ADDR_W-1:0] user_addr,
	output int                fails,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned UNITS     = POOL_BYTES_DEF / UNIT_BYTES_DEF;
	localparam int unsigned VAL_MASK  = 2 * UNITS - 1;
	localparam int unsigned WALK_MAX  = 4 * UNITS + 16;

	typedef struct {
		bit          ok;
		logic [15:0] addr;
	} answer_t;

	answer_t            answers_q[$];
	int unsigned        heap_hdr[UNITS];
	int unsigned        grow_ptr;
	bit                 exhausted;
	int unsigned        first_blk;
	bit                 first_ok;
	int unsigned        visits;

	function automatic int unsigned hval(int unsigned h);
		return (h >> 3) & VAL_MASK;
	endfunction

	function automatic void hdr_put(int unsigned u, int unsigned val, int unsigned fl);
		heap_hdr[u % UNITS] = ((val & VAL_MASK) << 3) | (fl & 7);
	endfunction

	function automatic int unsigned next_of(int unsigned u);
		return (u + hval(heap_hdr[u % UNITS]) + 1) % UNITS;
	endfunction

	function automatic bit walk_over();
		visits++;
		return visits > WALK_MAX;
	endfunction

	// cut a page-rounded chunk below the grow pointer
	function automatic bit grow_chunk(int unsigned align, output int unsigned base);
		longint unsigned bytes;
		longint unsigned n;
		bytes = longint'(align) * UNIT_BYTES_DEF;
		if (bytes % PAGE_BYTES_DEF != 0)
			bytes = bytes - (bytes % PAGE_BYTES_DEF) + PAGE_BYTES_DEF;
		else
			bytes = bytes + PAGE_BYTES_DEF;
		n = bytes / UNIT_BYTES_DEF;
		base = 0;
		if (exhausted || n > grow_ptr) begin
			exhausted = 1;
			return 0;
		end
		grow_ptr -= int'(n);
		base = grow_ptr;
		hdr_put(grow_ptr, n >= 2 ? int'(n - 2) : 0, FL_FREE);
		hdr_put(grow_ptr + int'(n) - 1, 0, FL_LAST);
		return 1;
	endfunction

	function automatic int unsigned coalesce(int unsigned b);
		int unsigned h;
		int unsigned t;
		int unsigned nh;
		h = heap_hdr[b % UNITS];
		t = hval(h);
		if ((h & FL_LAST) != 0 || (h & FL_FREE) == 0)
			return t;
		forever begin
			if (walk_over())
				return t;
			nh = heap_hdr[next_of(b)];
			if ((nh & FL_LAST) != 0 || (nh & FL_FREE) == 0)
				return t;
			t = (t + hval(nh) + 1) & VAL_MASK;
			hdr_put(b, t, FL_FREE);
		end
	endfunction

	function automatic bit alloc_word(int unsigned req, output int unsigned addr);
		int unsigned align;
		bit          fresh;
		int unsigned b;
		int unsigned h;
		int unsigned bsize;
		int unsigned link;
		align = (req + UNIT_BYTES_DEF - 1) / UNIT_BYTES_DEF;
		fresh = 0;
		addr = 0;
		if (!first_ok) begin
			if (!grow_chunk(align, link))
				return 0;
			first_blk = link;
			first_ok = 1;
			fresh = 1;
		end
		b = first_blk;
		forever begin
			if (walk_over())
				return 0;
			h = heap_hdr[b % UNITS];
			if ((h & FL_FREE) != 0) begin
				bsize = hval(h);
				if (bsize < align)
					bsize = coalesce(b);
				if (fresh && bsize < align) begin
					// fresh chunk still short: bump the request by two units
					req += 2 * UNIT_BYTES_DEF;
					align = (req + UNIT_BYTES_DEF - 1) / UNIT_BYTES_DEF;
					b = next_of(b);
				end else if (bsize >= align) begin
					hdr_put(b, align, FL_NONE);
					if (bsize > align)
						hdr_put((b + 1 + align) % UNITS, bsize - align - 1, FL_FREE);
					addr = ((b + 1) * UNIT_BYTES_DEF) & 16'hffff;
					return 1;
				end else begin
					b = next_of(b);
				end
			end else if ((h & FL_LAST) != 0) begin
				if ((h & FL_LINK) != 0) begin
					link = hval(h) % UNITS;
				end else begin
					if (!grow_chunk(align, link))
						return 0;
					fresh = 1;
					hdr_put(b, link, FL_LAST | FL_LINK);
				end
				b = link;
			end else begin
				b = next_of(b);
			end
		end
	endfunction

	function automatic void free_word(int unsigned addr);
		int unsigned b;
		int unsigned dummy;
		if (addr == 0)
			return;
		b = (addr / UNIT_BYTES_DEF + UNITS - 1) % UNITS;
		hdr_put(b, hval(heap_hdr[b]), FL_FREE);
		dummy = coalesce(b);
	endfunction

	assign pending = answers_q.size();

	always @(posedge clk or negedge arst_n) begin
		answer_t     want;
		int unsigned a;
		if (!arst_n) begin
			answers_q.delete();
			foreach (heap_hdr[i]) heap_hdr[i] = 0;
			grow_ptr = UNITS;
			exhausted = 0;
			first_blk = 0;
			first_ok = 0;
			fails = 0;
		end else begin
			if (start && !busy) begin
				visits = 0;
				a = 0;
				want.ok = 1;
				if (command == CMD_ALLOC)
					want.ok = alloc_word(req_bytes, a);
				else
					free_word(block_addr);
				want.addr = want.ok ? a[15:0] : 16'h0;
				answers_q.push_back(want);
			end
			if (done) begin
				if (answers_q.size() == 0) begin
					$error("result word with nothing expected");
					fails++;
				end else begin
					want = answers_q.pop_front();
					if (ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, ok);
						fails++;
					end
					if (user_addr !== want.addr) begin
						$error("user_addr: expected %h, got %h", want.addr, user_addr);
						fails++;
					end
				end
			end
		end
	end
endmodule

// ===== dv/tb_first_fit_heap_allocator.sv =====
module tb_first_fit_heap_allocator import ffha_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// far above any real run: even a walk that hits its visit bound on every
	// word stays below this
	localparam int CYCLE_LIMIT = 300000000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              command;
	logic [REQ_W-1:0]  req_bytes;
	logic [ADDR_W-1:0] block_addr;
	logic              done;
	logic              ok;
	logic [ADDR_W-1:0] user_addr;
	int                fails;
	int                pending;
	int                cycles;
	int                idle_pct;
	int                n_alloc;
	int                n_free;
	int                n_oom;
	logic [15:0]       live_q[$];

	first_fit_heap_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .req_bytes(req_bytes), .block_addr(block_addr),
		.done(done), .ok(ok), .user_addr(user_addr)
	);

	ffha_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .req_bytes(req_bytes), .block_addr(block_addr),
		.done(done), .ok(ok), .user_addr(user_addr),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung walk or a lost result ends up here
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_first_fit_heap_allocator failed");
			$finish;
		end
	end

	// collect handed-out addresses so frees can target headers that exist
	always @(posedge clk) begin
		if (done) begin
			if (ok && user_addr != 0)
				live_q.push_back(user_addr);
			if (!ok)
				n_oom++;
		end
	end

	// drive one word at the falling edge and hold it until the block takes it
	task automatic send_word(logic cmd, logic [15:0] size, logic [15:0] addr);
		int gap;
		@(negedge clk);
		start = 1;
		command = cmd;
		req_bytes = size;
		block_addr = addr;
		do @(posedge clk); while (busy);
		if (cmd == CMD_ALLOC)
			n_alloc++;
		else
			n_free++;
		// sender gap, sometimes long enough to straddle a whole walk
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			start = 0;
			command = 1'($urandom);
			req_bytes = 16'($urandom);
			block_addr = 16'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// wait for the result of everything sent so far
	task automatic drain();
		@(negedge clk);
		start = 0;
		while (pending != 0) @(posedge clk);
	endtask

	task automatic free_live(bit stale, bit odd);
		int          i;
		logic [15:0] a;
		i = $urandom_range(0, live_q.size() - 1);
		a = live_q[i];
		if (odd)
			a = a + 16'($urandom_range(1, 15));
		// keep the entry now and then so later frees hit stale or merged blocks
		if (!stale)
			live_q.delete(i);
		send_word(CMD_FREE, 16'($urandom), a);
	endtask

	task automatic random_word();
		int          r;
		logic [15:0] sz;
		r = $urandom_range(0, 99);
		if (live_q.size() != 0 && r < 45) begin
			free_live($urandom_range(0, 99) < 15, $urandom_range(0, 3) == 0);
		end else if (r < 47) begin
			send_word(CMD_FREE, 16'($urandom), 16'h0);
		end else begin
			r = $urandom_range(0, 999);
			if (r < 8)
				sz = 16'($urandom);
			else if (r < 200)
				sz = 16'($urandom_range(0, 8192));
			else
				sz = 16'($urandom_range(0, 256));
			send_word(CMD_ALLOC, sz, 16'($urandom));
		end
	endtask

	initial begin
		start = 0;
		command = CMD_ALLOC;
		req_bytes = 0;
		block_addr = 0;
		cycles = 0;
		n_alloc = 0;
		n_free = 0;
		n_oom = 0;
		idle_pct = 17;
		arst_n = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: size extremes, page multiple, short fresh chunk
		send_word(CMD_ALLOC, 16'd0, 16'hffff);
		send_word(CMD_ALLOC, 16'd1, 16'h0);
		send_word(CMD_ALLOC, 16'd16, 16'h0);
		send_word(CMD_ALLOC, 16'd17, 16'h0);
		send_word(CMD_ALLOC, 16'd4096, 16'h0);
		send_word(CMD_ALLOC, 16'd4080, 16'h0);
		send_word(CMD_ALLOC, 16'd4095, 16'h0);
		drain();
		// free of address zero, unaligned free, double free, reuse
		send_word(CMD_FREE, 16'hffff, 16'h0);
		free_live(0, 1);
		free_live(1, 0);
		drain();
		free_live(0, 0);
		free_live(0, 0);
		send_word(CMD_ALLOC, 16'd40, 16'h0);
		send_word(CMD_ALLOC, 16'd8, 16'h0);
		drain();

		// random, three sender idle profiles
		for (int i = 0; i < 1150; i++) begin
			if (i == 400)
				idle_pct = 48;
			if (i == 800)
				idle_pct = 0;
			if (i % 97 == 0)
				drain();
			random_word();
		end
		drain();

		// directed tail: oversized request fails the grow, later grows stay dead
		send_word(CMD_ALLOC, 16'hffff, 16'h0);
		send_word(CMD_ALLOC, 16'd8192, 16'h0);
		send_word(CMD_ALLOC, 16'd32, 16'h0);
		if (live_q.size() != 0)
			free_live(0, 0);
		drain();
		repeat (200) @(posedge clk);

		$display("covered %0d allocations (%0d out of memory) and %0d frees",
			n_alloc, n_oom, n_free);
		$display("sender idle at 17, 48 and 0 percent, with drains between");
		if (fails == 0)
			$display("tb_first_fit_heap_allocator passed");
		else
			$display("tb_first_fit_heap_allocator failed");
		$finish;
	end
endmodule
